>>> rtl/histogram_equalizer_top_defines.svh
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HEQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HEQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/heq_pkg.sv
package heq_pkg;

    localparam int MAX_PIXELS_LOG2 = 20;

    localparam int PIX_W      = 8;
    localparam int NUM_BINS   = 256;
    localparam int BIN_ADDR_W = 8;
    localparam int CNT_W      = MAX_PIXELS_LOG2 + 1;
    // 255 * count needs eight more bits than the count itself.
    localparam int PROD_W     = CNT_W + 8;
    localparam int QBIT_W     = 3;

    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [BIN_ADDR_W-1:0] bin_addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [PROD_W-1:0]     prod_t;
    typedef logic [QBIT_W-1:0]     qbit_t;

    localparam cnt_t CAPACITY = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_MAP   = 1'b1;

endpackage

>>> rtl/histogram_equalizer_top.sv
// Channel   Handshake          Fields
// -------   ----------------   ------------------------------
// input     start && !busy     opcode, pixel, last
// result    done (one cycle)   equalized_pixel, last_out
//
// A counting pixel holds busy high in ST_CNT_WR after its transfer, a mapping
// pixel in ST_MAP_OUT, with done there. A counting pixel with last set
// then builds the map bin by bin: read, accumulate, multiply, 8-step shared
// compare-subtract divider, write. Reset is asynchronous and active low; it
// clears the counts and the map at once through valid bits and a map flag.
// The receiver cannot stall; the result is shown for exactly one cycle.
`include "histogram_equalizer_top_defines.svh"

module histogram_equalizer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  heq_pkg::pix_t       pixel,
    input  logic                last,
    output logic                done,
    output heq_pkg::pix_t       equalized_pixel,
    output logic                last_out
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CNT_WR  = 3'd1;
    localparam logic [2:0] ST_BLD_RD  = 3'd2;
    localparam logic [2:0] ST_BLD_ACC = 3'd3;
    localparam logic [2:0] ST_BLD_MUL = 3'd4;
    localparam logic [2:0] ST_BLD_DIV = 3'd5;
    localparam logic [2:0] ST_BLD_WR  = 3'd6;
    localparam logic [2:0] ST_MAP_OUT = 3'd7;

    logic [2:0]                       state_reg, state_next;
    heq_pkg::pix_t                    pix_reg, pix_next;
    logic                             last_reg, last_next;
    heq_pkg::cnt_t                    total_reg, total_next;
    heq_pkg::cnt_t                    cum_reg, cum_next;
    heq_pkg::prod_t                   rem_reg, rem_next;
    heq_pkg::pix_t                    quo_reg, quo_next;
    heq_pkg::qbit_t                   bit_reg, bit_next;
    heq_pkg::bin_addr_t               idx_reg, idx_next;
    logic                             built_reg, built_next;
    logic [heq_pkg::NUM_BINS-1:0]     bin_valid_reg, bin_valid_next;

    logic                             bin_we;
    heq_pkg::bin_addr_t               bin_rd_addr;
    heq_pkg::cnt_t                    bin_rd_data;
    heq_pkg::cnt_t                    bin_cur;
    heq_pkg::bin_addr_t               bin_sel;
    logic                             map_we;
    heq_pkg::pix_t                    map_wr_data;
    heq_pkg::pix_t                    map_rd_data;
    heq_pkg::prod_t                   div_shifted;
    logic [heq_pkg::PROD_W:0]         div_trial;

    assign bin_rd_addr = (state_reg == ST_IDLE) ? pixel : idx_reg;
    assign bin_sel     = (state_reg == ST_CNT_WR) ? pix_reg : idx_reg;
    // An entry whose valid bit is clear was never written or has been cleared since.
    assign bin_cur     = bin_valid_reg[bin_sel] ? bin_rd_data : '0;

    assign div_shifted = heq_pkg::prod_t'(total_reg) << bit_reg;
    assign div_trial   = {1'b0, rem_reg} - {1'b0, div_shifted};
    assign map_wr_data = (total_reg == '0) ? '0 : quo_reg;

    heq_ram #(
        .WIDTH (heq_pkg::CNT_W),
        .DEPTH (heq_pkg::NUM_BINS)
    ) u_bin_ram (
        .clk     (clk),
        .we      (bin_we),
        .wr_addr (pix_reg),
        .wr_data (bin_cur + heq_pkg::cnt_t'(1)),
        .rd_addr (bin_rd_addr),
        .rd_data (bin_rd_data)
    );

    heq_ram #(
        .WIDTH (heq_pkg::PIX_W),
        .DEPTH (heq_pkg::NUM_BINS)
    ) u_map_ram (
        .clk     (clk),
        .we      (map_we),
        .wr_addr (idx_reg),
        .wr_data (map_wr_data),
        .rd_addr (pixel),
        .rd_data (map_rd_data)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_MAP_OUT);
    assign equalized_pixel = built_reg ? map_rd_data : '0;
    assign last_out        = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;
        total_next     = total_reg;
        cum_next       = cum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        built_next     = built_reg;
        bin_valid_next = bin_valid_reg;
        bin_we         = 1'b0;
        map_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pix_next   = pixel;
                    last_next  = last;
                    state_next = (opcode == heq_pkg::OP_MAP) ? ST_MAP_OUT : ST_CNT_WR;
                end
            end
            ST_CNT_WR:
            begin
                // Pixels beyond the capacity are dropped, but last still counts.
                if (total_reg != heq_pkg::CAPACITY)
                begin
                    bin_we                  = 1'b1;
                    bin_valid_next[pix_reg] = 1'b1;
                    total_next              = total_reg + heq_pkg::cnt_t'(1);
                end
                if (last_reg)
                begin
                    idx_next   = '0;
                    cum_next   = '0;
                    state_next = ST_BLD_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLD_RD:
            begin
                state_next = ST_BLD_ACC;
            end
            ST_BLD_ACC:
            begin
                cum_next   = cum_reg + bin_cur;
                state_next = ST_BLD_MUL;
            end
            ST_BLD_MUL:
            begin
                rem_next   = (heq_pkg::prod_t'(cum_reg) << 8) - heq_pkg::prod_t'(cum_reg);
                quo_next   = '0;
                bit_next   = '1;
                state_next = ST_BLD_DIV;
            end
            ST_BLD_DIV:
            begin
                // The quotient never exceeds 255, so eight restoring steps suffice.
                if (!div_trial[heq_pkg::PROD_W])
                begin
                    rem_next          = div_trial[heq_pkg::PROD_W-1:0];
                    quo_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_BLD_WR;
                end
                else
                begin
                    bit_next = bit_reg - heq_pkg::qbit_t'(1);
                end
            end
            ST_BLD_WR:
            begin
                map_we = 1'b1;
                if (idx_reg == heq_pkg::bin_addr_t'(heq_pkg::NUM_BINS - 1))
                begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + heq_pkg::bin_addr_t'(1);
                    state_next = ST_BLD_RD;
                end
            end
            ST_MAP_OUT:
            begin
                if (last_reg)
                begin
                    bin_valid_next = '0;
                    total_next     = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            built_reg     <= 1'b0;
            bin_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            built_reg     <= built_next;
            bin_valid_reg <= bin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        last_reg <= last_next;
        cum_reg  <= cum_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        idx_reg  <= idx_next;
    end

    `HEQ_ASSERT_NEXT(a_map_answered, start && !busy && opcode == heq_pkg::OP_MAP, done, "mapping pixel not answered in the next cycle")
    `HEQ_ASSERT_IMPL(a_total_capped, 1'b1, total_reg <= heq_pkg::CAPACITY, "pixel total beyond capacity")
    `HEQ_ASSERT_IMPL(a_div_remainder, state_reg == ST_BLD_WR && total_reg != '0, rem_reg < heq_pkg::prod_t'(total_reg), "divider remainder not below the total")
    `HEQ_ASSERT_IMPL(a_cum_bounded, state_reg == ST_BLD_MUL || state_reg == ST_BLD_DIV || state_reg == ST_BLD_WR, cum_reg <= total_reg, "cumulative count above the total")
    `HEQ_ASSERT_NEXT(a_counts_cleared, done && last_out, total_reg == '0, "counts not cleared after the last mapped pixel")

endmodule

>>> rtl/heq_ram.sv
module heq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
